/* design/efla_pkg.sv */
// ---------------------------------------------------------------------------
// efla_pkg: shared types and constants for the free list allocator
// Holds operation and status codes, byte constants of the block format and
// the result record that travels from the sequencer to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

  // Internal byte offsets, sizes and links are kept at this width.
  localparam int OFF_W = 20;

  localparam int HEAP_WORDS_DEF  = 4096;
  localparam int ALIGN_BYTES_DEF = 8;
  localparam int MAX_REQUEST_DEF = 32768;

  localparam logic [15:0] HEAP_BYTES_RST = 16'd32768;

  localparam logic [OFF_W-1:0] HDR_BYTES   = OFF_W'(8);
  localparam logic [OFF_W-1:0] MIN_PAYLOAD = OFF_W'(16);
  localparam logic [OFF_W-1:0] MIN_SEG     = OFF_W'(24);

  typedef logic [OFF_W-1:0] off_t;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_NOT_INIT  = 3'd4
  } status_t;

  typedef struct packed {
    logic        done;
    logic [2:0]  status;
    logic [15:0] payload;
    logic [15:0] used;
  } res_t;

endpackage

`default_nettype wire

/* design/efla_if.sv */
// ---------------------------------------------------------------------------
// efla_if: request and response channel interfaces
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface efla_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] request_bytes;
  logic [15:0] block_offset;

  modport source (output valid, operation, request_bytes, block_offset, input ready);
  modport sink   (input valid, operation, request_bytes, block_offset, output ready);
endinterface

interface efla_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] payload_offset;
  logic [15:0] bytes_in_use;

  modport source (output valid, status, payload_offset, bytes_in_use, input ready);
  modport sink   (input valid, status, payload_offset, bytes_in_use, output ready);
endinterface

`default_nettype wire

/* design/explicit_free_list_allocator.sv */
// ---------------------------------------------------------------------------
// explicit_free_list_allocator: first fit heap allocator, LIFO free list
// Keeps headers and list links inside a heap memory, with a config register
// for the segment size and a registered response stage.
// ---------------------------------------------------------------------------
//  channel   dir  words
//  in_req    in   operation, request_bytes, block_offset
//  out_rsp   out  status, payload_offset, bytes_in_use
//  cfg_*     in   heap_bytes write (cfg_we, cfg_wdata)
//
// One memory access per cycle sets the pace; an allocate walks the free list
// node by node before it edits headers and links.
// Reset is synchronous; the heap memory is not cleared and has no sweep.
// A new word is taken while the previous result waits in the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module explicit_free_list_allocator #(
  parameter int HEAP_WORDS  = efla_pkg::HEAP_WORDS_DEF,
  parameter int ALIGN_BYTES = efla_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_REQUEST = efla_pkg::MAX_REQUEST_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  efla_req_if.sink         in_req,
  efla_rsp_if.source       out_rsp,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]    heap_bytes_r;
  logic           out_valid_r;
  logic [2:0]     status_r;
  logic [15:0]    payload_r, used_r;
  logic           res_free;
  efla_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= efla_pkg::HEAP_BYTES_RST;
    end else if (cfg_we) begin
      heap_bytes_r <= cfg_wdata;
    end
  end

  assign res_free = !out_valid_r || out_rsp.ready;

  efla_ctrl #(
    .HEAP_WORDS  (HEAP_WORDS),
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .heap_bytes (heap_bytes_r),
    .res_free   (res_free),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      status_r  <= res.status;
      payload_r <= res.payload;
      used_r    <= res.used;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = status_r;
  assign out_rsp.payload_offset = payload_r;
  assign out_rsp.bytes_in_use   = used_r;

  // A finished result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (!out_valid_r || out_rsp.ready))
    else $error("result overwrote a pending response");

  // The sequencer is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while busy");

  // Only a good allocate returns a payload offset.
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && payload_r != 16'd0) |-> (status_r == efla_pkg::ST_OK))
    else $error("payload offset with failing status");

  // Status codes stay within the defined range.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= efla_pkg::ST_NOT_INIT))
    else $error("undefined status code");

endmodule

`default_nettype wire

/* design/efla_heap_mem.sv */
// ---------------------------------------------------------------------------
// efla_heap_mem: heap word storage
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module efla_heap_mem #(
  parameter int DEPTH = efla_pkg::HEAP_WORDS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = efla_pkg::OFF_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/efla_ctrl.sv */
// ---------------------------------------------------------------------------
// efla_ctrl: allocator sequencer
// Walks the free list and edits headers and links in the heap memory, one
// memory read or write per cycle, and keeps list head and usage counters.
// ---------------------------------------------------------------------------
`default_nettype none

module efla_ctrl #(
  parameter int HEAP_WORDS  = efla_pkg::HEAP_WORDS_DEF,
  parameter int ALIGN_BYTES = efla_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_REQUEST = efla_pkg::MAX_REQUEST_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  efla_req_if.sink            req,
  input  wire logic [15:0]    heap_bytes,
  input  wire logic           res_free,
  output efla_pkg::res_t      res
);

  localparam int OW     = efla_pkg::OFF_W;
  localparam int AW     = $clog2(HEAP_WORDS);
  localparam int IW     = OW - 3;
  localparam int STEP_W = $clog2(HEAP_WORDS + 1);
  localparam logic [OW-1:0]     CAP     = OW'(HEAP_WORDS * 8);
  localparam logic [OW-1:0]     ALIGN_M = OW'(ALIGN_BYTES - 1);
  localparam logic [STEP_W-1:0] STEP_MX = STEP_W'(HEAP_WORDS);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_WALK, S_A_HDR, S_A_NEXT,
    S_UL_P, S_UL_X, S_UL_W2, S_A_HW, S_A_RW, S_F_HDR, S_F_NB, S_F_HW,
    S_PUSH0, S_PUSH1, S_PUSH2, S_FIN
  } state_t;

  state_t                state_r;
  efla_pkg::op_t         op_r;
  logic [OW-1:0]         need_r, off_r, seg_r, head_r, size_r, take_r;
  logic [OW-1:0]         pnode_r, ulnode_r, p_r, x_r;
  logic                  split_r, ready_r;
  logic [15:0]           used_r, payload_r;
  logic [STEP_W-1:0]     steps_r;
  efla_pkg::status_t     status_r;

  logic                  fire;
  logic [OW-1:0]         rdw, rsize, take_c, seg_c, need_c, in_off, hb;
  logic [OW:0]           end_c, split_lim;
  logic                  fit_c, split_c, req_bad;
  logic                  we, re;
  logic [OW-1:0]         waddr_b, wdata, raddr_b;
  logic [IW-1:0]         widx;
  logic [AW-1:0]         mem_waddr, mem_raddr;

  assign req.ready = (state_r == S_IDLE);
  assign fire      = req.valid && req.ready;

  assign in_off  = OW'(req.block_offset);
  assign need_c  = (OW'(req.request_bytes) + ALIGN_M) & ~ALIGN_M;
  assign req_bad = (req.request_bytes == 16'd0) ||
                   ({16'd0, req.request_bytes} > 32'(MAX_REQUEST));
  assign hb      = OW'(heap_bytes & 16'hFFF8);
  assign seg_c   = (hb > CAP) ? CAP : hb;

  assign rsize     = {rdw[OW-1:1], 1'b0};
  assign take_c    = (need_r < efla_pkg::MIN_PAYLOAD) ? efla_pkg::MIN_PAYLOAD : need_r;
  assign fit_c     = (need_r <= rsize);
  assign end_c     = {1'b0, off_r} + {1'b0, rsize};
  assign split_lim = {1'b0, take_c} + {1'b0, efla_pkg::MIN_SEG};
  assign split_c   = (end_c == {1'b0, seg_r}) && ({1'b0, rsize} >= split_lim);

  // Memory port selection; each state issues at most one read or one write.
  always_comb begin
    we      = 1'b0;
    waddr_b = '0;
    wdata   = '0;
    re      = 1'b0;
    raddr_b = '0;
    unique case (state_r)
      S_IDLE: begin
        re      = fire;
        raddr_b = in_off - efla_pkg::HDR_BYTES;
      end
      S_INIT0: begin
        we      = 1'b1;
        waddr_b = '0;
        wdata   = seg_r - efla_pkg::HDR_BYTES;
      end
      S_INIT1: begin
        we      = 1'b1;
        waddr_b = OW'(8);
      end
      S_INIT2: begin
        we      = 1'b1;
        waddr_b = OW'(16);
      end
      S_WALK: begin
        re      = 1'b1;
        raddr_b = off_r - efla_pkg::HDR_BYTES;
      end
      S_A_HDR: begin
        re      = 1'b1;
        raddr_b = fit_c ? off_r : off_r + efla_pkg::HDR_BYTES;
      end
      S_UL_P: begin
        re      = 1'b1;
        raddr_b = ulnode_r + efla_pkg::HDR_BYTES;
      end
      S_UL_X: begin
        we      = (p_r != '0);
        waddr_b = p_r + efla_pkg::HDR_BYTES;
        wdata   = rdw;
      end
      S_UL_W2: begin
        we      = (x_r != '0);
        waddr_b = x_r;
        wdata   = p_r;
      end
      S_A_HW: begin
        we      = 1'b1;
        waddr_b = off_r - efla_pkg::HDR_BYTES;
        wdata   = split_r ? (take_r | OW'(1)) : (size_r | OW'(1));
      end
      S_A_RW: begin
        we      = 1'b1;
        waddr_b = off_r + take_r;
        wdata   = size_r - efla_pkg::HDR_BYTES - take_r;
      end
      S_F_HDR: begin
        re      = 1'b1;
        raddr_b = off_r + rsize;
      end
      S_F_NB: begin
        re      = 1'b1;
        raddr_b = off_r + size_r + efla_pkg::HDR_BYTES;
      end
      S_F_HW: begin
        we      = 1'b1;
        waddr_b = off_r - efla_pkg::HDR_BYTES;
        wdata   = size_r;
      end
      S_PUSH0: begin
        we      = 1'b1;
        waddr_b = pnode_r;
      end
      S_PUSH1: begin
        we      = 1'b1;
        waddr_b = pnode_r + efla_pkg::HDR_BYTES;
        wdata   = head_r;
      end
      S_PUSH2: begin
        we      = (head_r != '0);
        waddr_b = head_r;
        wdata   = pnode_r;
      end
      default: begin
      end
    endcase
  end

  // Writes beyond the memory are dropped.
  assign widx      = waddr_b[OW-1:3];
  assign mem_waddr = widx[AW-1:0];
  assign mem_raddr = raddr_b[AW+2:3];

  efla_heap_mem #(
    .DEPTH (HEAP_WORDS),
    .AW    (AW),
    .DW    (OW)
  ) u_mem (
    .clk   (clk),
    .we    (we && (widx < IW'(HEAP_WORDS))),
    .waddr (mem_waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (mem_raddr),
    .rdata (rdw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      used_r   <= '0;
      ready_r  <= 1'b0;
      seg_r    <= '0;
      status_r <= efla_pkg::ST_OK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (fire) begin
            op_r      <= efla_pkg::op_t'(req.operation);
            off_r     <= (efla_pkg::op_t'(req.operation) == efla_pkg::OP_ALLOC) ?
                         head_r : in_off;
            need_r    <= need_c;
            payload_r <= '0;
            steps_r   <= '0;
            unique case (efla_pkg::op_t'(req.operation))
              efla_pkg::OP_INIT: begin
                if (seg_c < efla_pkg::MIN_SEG) begin
                  status_r <= efla_pkg::ST_TOO_SMALL;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= efla_pkg::ST_OK;
                  seg_r    <= seg_c;
                  state_r  <= S_INIT0;
                end
              end
              efla_pkg::OP_ALLOC: begin
                priority if (!ready_r) begin
                  status_r <= efla_pkg::ST_NOT_INIT;
                  state_r  <= S_FIN;
                end else if (req_bad) begin
                  status_r <= efla_pkg::ST_BAD_SIZE;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= efla_pkg::ST_OK;
                  state_r  <= S_WALK;
                end
              end
              efla_pkg::OP_FREE: begin
                priority if (!ready_r) begin
                  status_r <= efla_pkg::ST_NOT_INIT;
                  state_r  <= S_FIN;
                end else if (in_off != '0 && in_off[2:0] == 3'd0 && in_off < seg_r) begin
                  status_r <= efla_pkg::ST_OK;
                  state_r  <= S_F_HDR;
                end else begin
                  status_r <= efla_pkg::ST_OK;
                  state_r  <= S_FIN;
                end
              end
              default: begin
                status_r <= efla_pkg::ST_OK;
                state_r  <= S_FIN;
              end
            endcase
          end
        end
        S_INIT0: state_r <= S_INIT1;
        S_INIT1: state_r <= S_INIT2;
        S_INIT2: begin
          head_r  <= efla_pkg::HDR_BYTES;
          used_r  <= '0;
          ready_r <= 1'b1;
          state_r <= S_FIN;
        end
        S_WALK: begin
          if (steps_r == STEP_MX || off_r < efla_pkg::HDR_BYTES || off_r >= seg_r) begin
            status_r <= efla_pkg::ST_NO_FIT;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_A_HDR;
          end
        end
        S_A_HDR: begin
          if (fit_c) begin
            size_r   <= rsize;
            take_r   <= take_c;
            split_r  <= split_c;
            ulnode_r <= off_r;
            state_r  <= S_UL_P;
          end else begin
            state_r <= S_A_NEXT;
          end
        end
        S_A_NEXT: begin
          off_r   <= rdw;
          steps_r <= steps_r + STEP_W'(1);
          if (rdw == '0) begin
            status_r <= efla_pkg::ST_NO_FIT;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_UL_P: begin
          p_r     <= rdw;
          state_r <= S_UL_X;
        end
        S_UL_X: begin
          x_r <= rdw;
          if (p_r == '0) begin
            head_r <= rdw;
          end
          state_r <= S_UL_W2;
        end
        S_UL_W2: begin
          state_r <= (op_r == efla_pkg::OP_ALLOC) ? S_A_HW : S_F_HW;
        end
        S_A_HW: begin
          payload_r <= off_r[15:0];
          if (split_r) begin
            used_r  <= used_r + take_r[15:0];
            state_r <= S_A_RW;
          end else begin
            used_r  <= used_r + size_r[15:0];
            state_r <= S_FIN;
          end
        end
        S_A_RW: begin
          pnode_r <= off_r + take_r + efla_pkg::HDR_BYTES;
          state_r <= S_PUSH0;
        end
        S_F_HDR: begin
          // Not an allocated block, or one running past the segment: ignore.
          if (!rdw[0] || ({1'b0, off_r} + {1'b0, rsize}) > {1'b0, seg_r}) begin
            state_r <= S_FIN;
          end else begin
            size_r  <= rsize;
            used_r  <= (OW'(used_r) >= rsize) ? used_r - rsize[15:0] : 16'd0;
            state_r <= ((off_r + rsize) < seg_r) ? S_F_NB : S_F_HW;
          end
        end
        S_F_NB: begin
          if (!rdw[0]) begin
            ulnode_r <= off_r + size_r + efla_pkg::HDR_BYTES;
            size_r   <= size_r + efla_pkg::HDR_BYTES + rsize;
            state_r  <= S_UL_P;
          end else begin
            state_r <= S_F_HW;
          end
        end
        S_F_HW: begin
          pnode_r <= off_r;
          state_r <= S_PUSH0;
        end
        S_PUSH0: state_r <= S_PUSH1;
        S_PUSH1: state_r <= S_PUSH2;
        S_PUSH2: begin
          head_r  <= pnode_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (res_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.done    = (state_r == S_FIN) && res_free;
    res.status  = status_r;
    res.payload = payload_r;
    res.used    = used_r;
  end

endmodule

`default_nettype wire

/* tb/sv/efla_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// efla_checker: result checker for the free list allocator
// Watches the request, response and configuration ports, keeps its own copy
// of the heap, list head and byte count, predicts each response word and
// compares it field by field against what the block returns.
// ---------------------------------------------------------------------------
`default_nettype none

module efla_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  efla_req_if              req_mon,
  efla_rsp_if              rsp_mon,
  output int               err_count,
  output int               pending
);

  localparam int unsigned WORDS   = efla_pkg::HEAP_WORDS_DEF;
  localparam int unsigned ALIGN   = efla_pkg::ALIGN_BYTES_DEF;
  localparam int unsigned MAX_REQ = efla_pkg::MAX_REQUEST_DEF;
  localparam int unsigned HDR     = 8;
  localparam int unsigned MINPAY  = 16;
  localparam int unsigned LINKMSK = 32'hFFFFF;

  typedef struct {
    efla_pkg::status_t st;
    logic [15:0]       payload;
    logic [15:0]       used;
  } alloc_rsp_t;

  logic [63:0]  heap_mem [WORDS];
  int unsigned  list_head;
  int unsigned  in_use_bytes;
  int unsigned  seg_size;
  int unsigned  seg_cfg;
  bit           heap_live;
  alloc_rsp_t   expected_rsp_q[$];
  int           fails;

  initial begin
    for (int i = 0; i < WORDS; i++) heap_mem[i] = '0;
    fails = 0;
  end

  function automatic logic [63:0] mem_rd(int unsigned a);
    int unsigned i;
    i = a >> 3;
    return (i < WORDS) ? heap_mem[i] : 64'd0;
  endfunction

  function automatic void mem_wr(int unsigned a, logic [63:0] v);
    int unsigned i;
    i = a >> 3;
    if (i < WORDS) heap_mem[i] = v;
  endfunction

  function automatic void list_unlink(int unsigned node);
    int unsigned p, x;
    p = int'(mem_rd(node)) & LINKMSK;
    x = int'(mem_rd(node + 8)) & LINKMSK;
    if (p == 0) list_head = x;
    else mem_wr(p + 8, 64'(x));
    if (x != 0) mem_wr(x, 64'(p));
  endfunction

  function automatic void list_push(int unsigned node);
    mem_wr(node, 64'd0);
    mem_wr(node + 8, 64'(list_head));
    if (list_head != 0) mem_wr(list_head, 64'(node));
    list_head = node;
  endfunction

  function automatic efla_pkg::status_t heap_init();
    int unsigned seg;
    seg = seg_cfg & ~32'd7;
    if (seg > WORDS * 8) seg = WORDS * 8;
    if (seg < HDR + MINPAY) return efla_pkg::ST_TOO_SMALL;
    seg_size = seg;
    mem_wr(0, 64'(seg - HDR));
    mem_wr(8, 64'd0);
    mem_wr(16, 64'd0);
    list_head    = HDR;
    in_use_bytes = 0;
    heap_live    = 1'b1;
    return efla_pkg::ST_OK;
  endfunction

  function automatic efla_pkg::status_t heap_alloc(int unsigned req,
                                                   output int unsigned pay);
    int unsigned need, node, hdr, size, take, nh;
    bit at_end;
    pay = 0;
    if (!heap_live) return efla_pkg::ST_NOT_INIT;
    if (req == 0 || req > MAX_REQ) return efla_pkg::ST_BAD_SIZE;
    need = (req + ALIGN - 1) & ~(ALIGN - 1);
    node = list_head;
    for (int unsigned n = 0; n < WORDS; n++) begin
      if (node < HDR || node >= seg_size) return efla_pkg::ST_NO_FIT;
      hdr  = node - HDR;
      size = int'(mem_rd(hdr)) & 32'hFFFFE;
      if (need <= size) begin
        take   = (need < MINPAY) ? MINPAY : need;
        at_end = (hdr + HDR + size == seg_size);
        list_unlink(node);
        // Only the block that ends the segment is split; the rest go whole.
        if (at_end && size >= take + HDR + MINPAY) begin
          nh = hdr + HDR + take;
          mem_wr(hdr, 64'(take | 1));
          mem_wr(nh, 64'(size - HDR - take));
          list_push(nh + HDR);
          in_use_bytes += take;
        end else begin
          mem_wr(hdr, 64'(size | 1));
          in_use_bytes += size;
        end
        in_use_bytes &= 32'hFFFF;
        pay = node;
        return efla_pkg::ST_OK;
      end
      node = int'(mem_rd(node + 8)) & LINKMSK;
      if (node == 0) return efla_pkg::ST_NO_FIT;
    end
    return efla_pkg::ST_NO_FIT;
  endfunction

  function automatic efla_pkg::status_t heap_free(int unsigned off);
    int unsigned hdr, size, nb;
    logic [63:0] w, nw;
    if (!heap_live) return efla_pkg::ST_NOT_INIT;
    if (off == 0 || (off & 7) != 0 || off >= seg_size) return efla_pkg::ST_OK;
    hdr = off - HDR;
    w   = mem_rd(hdr);
    if (w[0] == 1'b0 || (w >> 20) != 0) return efla_pkg::ST_OK;
    size = int'(w[19:0]) & ~32'd1;
    if (hdr + HDR + size > seg_size) return efla_pkg::ST_OK;
    in_use_bytes = (in_use_bytes >= size) ? in_use_bytes - size : 0;
    nb = hdr + HDR + size;
    // The segment end counts as a used neighbor, so no merge there.
    if (nb < seg_size) begin
      nw = mem_rd(nb);
      if (nw[0] == 1'b0) begin
        list_unlink(nb + HDR);
        size += HDR + (int'(nw[19:0]) & 32'hFFFFE);
      end
    end
    mem_wr(hdr, 64'(size));
    list_push(off);
    return efla_pkg::ST_OK;
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t  exp_w;
    int unsigned pay;
    if (!rst_n) begin
      list_head    = 0;
      in_use_bytes = 0;
      heap_live    = 1'b0;
      seg_size     = 0;
      seg_cfg      = 32'(efla_pkg::HEAP_BYTES_RST);
      expected_rsp_q.delete();
    end else begin
      if (cfg_we) seg_cfg = 32'(cfg_wdata);
      if (req_mon.valid && req_mon.ready) begin
        pay = 0;
        case (efla_pkg::op_t'(req_mon.operation))
          efla_pkg::OP_INIT:  exp_w.st = heap_init();
          efla_pkg::OP_ALLOC: exp_w.st = heap_alloc(32'(req_mon.request_bytes), pay);
          efla_pkg::OP_FREE:  exp_w.st = heap_free(32'(req_mon.block_offset));
          default:            exp_w.st = efla_pkg::ST_OK;
        endcase
        exp_w.payload = pay[15:0];
        exp_w.used    = in_use_bytes[15:0];
        expected_rsp_q.push_back(exp_w);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response word with nothing expected: status %0d", rsp_mon.status);
          fails++;
        end else begin
          exp_w = expected_rsp_q.pop_front();
          if (rsp_mon.status !== exp_w.st) begin
            $error("status: expected %0d, got %0d", exp_w.st, rsp_mon.status);
            fails++;
          end
          if (rsp_mon.payload_offset !== exp_w.payload) begin
            $error("payload_offset: expected %0d, got %0d", exp_w.payload,
                   rsp_mon.payload_offset);
            fails++;
          end
          if (rsp_mon.bytes_in_use !== exp_w.used) begin
            $error("bytes_in_use: expected %0d, got %0d", exp_w.used,
                   rsp_mon.bytes_in_use);
            fails++;
          end
        end
      end
    end
    pending   <= expected_rsp_q.size();
    err_count <= fails;
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the free list allocator
// Runs a directed opening over the error and corner cases, then phases of
// random allocate and free traffic, each phase on a fresh segment size.
// Frees target live, freed, null, unaligned and out of range offsets.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int TARGET_WORDS = 1750;
  localparam int CYCLE_LIMIT  = 20_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          err_count;
  int          pending;
  int          cycles = 0;
  int          sent;
  bit          calm;
  int          stall_left;
  int unsigned live_q[$];
  int unsigned freed_q[$];

  efla_req_if req_ch();
  efla_rsp_if rsp_ch();

  explicit_free_list_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch.sink),
    .out_rsp   (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  efla_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left   <= 0;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left <= gap_len();
    end
  end

  // Learn handed-out blocks from the responses.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == efla_pkg::ST_OK &&
        rsp_ch.payload_offset != 16'd0)
      live_q.push_back(32'(rsp_ch.payload_offset));
  end

  task automatic send_word(efla_pkg::op_t op, int unsigned nbytes, int unsigned off);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.request_bytes <= nbytes[15:0];
    req_ch.block_offset  <= off[15:0];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_heap_bytes(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic new_segment(logic [15:0] v);
    drain();
    live_q.delete();
    freed_q.delete();
    write_heap_bytes(v);
    send_word(efla_pkg::OP_INIT, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 8)  return $urandom_range(32769, 65535);
    if (r < 10) return 32768;
    if (r < 68) return $urandom_range(1, 64);
    if (r < 92) return $urandom_range(65, 512);
    return $urandom_range(513, 4096);
  endfunction

  function automatic int unsigned pick_free();
    int r, k;
    int unsigned v, off;
    r = $urandom_range(0, 99);
    if (r < 60 && live_q.size() > 0) begin
      k   = $urandom_range(0, live_q.size() - 1);
      off = live_q[k];
      live_q.delete(k);
      freed_q.push_back(off);
      return off;
    end
    if (r < 70 && freed_q.size() > 0)
      return freed_q[$urandom_range(0, freed_q.size() - 1)];
    if (r < 76) return 0;
    if (r < 88) begin
      v = $urandom_range(0, 65535);
      if (v[2:0] == 3'd0) v[0] = 1'b1;
      return v;
    end
    return $urandom_range(32768, 65535) & ~32'd7;
  endfunction

  function automatic logic [15:0] pick_heap_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(24, 1024));
    if (r < 80) return 16'($urandom_range(1025, 8192));
    if (r < 85) return 16'($urandom_range(0, 23));
    if (r < 90) return 16'd32768;
    if (r < 95) return 16'hFFFF;
    return 16'($urandom_range(8193, 65535));
  endfunction

  initial begin
    int phase_len, r;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.operation     = efla_pkg::OP_INIT;
    req_ch.request_bytes = '0;
    req_ch.block_offset  = '0;
    sent                 = 0;
    calm                 = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening: nothing works before init, then tiny and full size heaps.
    send_word(efla_pkg::OP_ALLOC, 16, 0);
    send_word(efla_pkg::OP_FREE, 0, 8);
    send_word(efla_pkg::OP_NONE, 65535, 65535);
    drain();
    write_heap_bytes(16'd16);
    send_word(efla_pkg::OP_INIT, 0, 0);
    send_word(efla_pkg::OP_ALLOC, 8, 0);
    drain();
    write_heap_bytes(16'd24);
    send_word(efla_pkg::OP_INIT, 0, 0);
    send_word(efla_pkg::OP_ALLOC, 16, 0);
    send_word(efla_pkg::OP_ALLOC, 1, 0);
    send_word(efla_pkg::OP_FREE, 0, 8);
    send_word(efla_pkg::OP_FREE, 0, 0);
    send_word(efla_pkg::OP_FREE, 0, 12);
    send_word(efla_pkg::OP_FREE, 0, 24);
    send_word(efla_pkg::OP_ALLOC, 0, 0);
    send_word(efla_pkg::OP_ALLOC, 32769, 0);
    send_word(efla_pkg::OP_ALLOC, 65535, 0);
    drain();
    write_heap_bytes(16'hFFFF);
    send_word(efla_pkg::OP_INIT, 0, 0);
    send_word(efla_pkg::OP_ALLOC, 32768, 0);
    send_word(efla_pkg::OP_ALLOC, 32760, 0);
    send_word(efla_pkg::OP_FREE, 0, 8);
    send_word(efla_pkg::OP_ALLOC, 8, 0);
    send_word(efla_pkg::OP_ALLOC, 9, 0);
    send_word(efla_pkg::OP_FREE, 0, 32);
    send_word(efla_pkg::OP_FREE, 0, 8);
    send_word(efla_pkg::OP_FREE, 0, 8);
    drain();
    live_q.delete();

    while (sent < TARGET_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      new_segment(pick_heap_bytes());
      phase_len = $urandom_range(100, 250);
      for (int i = 0; i < phase_len && sent < TARGET_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60)      send_word(efla_pkg::OP_ALLOC, pick_size(),
                                   $urandom_range(0, 65535));
        else if (r < 96) send_word(efla_pkg::OP_FREE, $urandom_range(0, 65535),
                                   pick_free());
        else             send_word(efla_pkg::OP_NONE, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
      end
    end

    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
